### design/paws_pkg.sv
// Shared types, field layout and arithmetic constants of the warp sampler.
package paws_pkg;

    localparam int PIXEL_DEPTH   = 65536;
    localparam int PIX_AW        = $clog2(PIXEL_DEPTH);
    localparam int FRACTION_BITS = 8;
    localparam int POINT_FRAC    = 22;
    localparam int SCALE         = 1 << FRACTION_BITS;
    localparam int SCALE_W       = FRACTION_BITS + 1;
    localparam int ROUND_HALF    = 1 << (2 * FRACTION_BITS - 1);
    localparam int LEFT_W        = FRACTION_BITS + 8;

    localparam int ADDR_W   = 16;
    localparam int PIXEL_W  = 24;
    localparam int WEIGHT_W = 18;
    localparam int VERTEX_W = 16;
    localparam int DIM_W    = 11;
    localparam int COORD_W  = 16;

    localparam int MUL_W = (LEFT_W + 1 > WEIGHT_W) ? LEFT_W + 1 : WEIGHT_W;
    localparam int ACC_W = 2 * MUL_W;

    localparam int OFS_ADDR  = 0;
    localparam int OFS_PIXEL = OFS_ADDR + ADDR_W;
    localparam int OFS_WA    = OFS_PIXEL + PIXEL_W;
    localparam int OFS_WB    = OFS_WA + WEIGHT_W;
    localparam int OFS_WC    = OFS_WB + WEIGHT_W;
    localparam int OFS_X1    = OFS_WC + WEIGHT_W;
    localparam int OFS_Y1    = OFS_X1 + VERTEX_W;
    localparam int OFS_X2    = OFS_Y1 + VERTEX_W;
    localparam int OFS_Y2    = OFS_X2 + VERTEX_W;
    localparam int OFS_X3    = OFS_Y2 + VERTEX_W;
    localparam int OFS_Y3    = OFS_X3 + VERTEX_W;
    localparam int IN_DATA_W = 192;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic [DIM_W-1:0] DIM_RESET = 11'd256;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOCATE,
        ST_CLAMP,
        ST_ROWS,
        ST_FETCH,
        ST_BLEND,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic en;
        logic clear;
    } t_mac_ctrl;

endpackage

### design/piecewise_affine_warp_sampler.sv
// Top level of the piecewise affine warp sampler with bilinear blending.
//
// Input stream: s_axis_tuser selects the command. A write transfer stores
// write_pixel at write_address in the image store; the block stays ready.
// A sample transfer carries three signed Q2.16 weights and three Q10.6
// vertices. The block then runs a fixed sequence on one shared
// multiply-accumulate unit: the weighted point, floor and clamp, the two
// row bases, the four neighbour reads from the single-port store and the
// blend of the three channels, one channel after another.
// The result then appears on the output stream; the next item is taken
// no earlier than the cycle after the result transfer, so no new item
// is taken while a sample is in progress.
// Output stream: m_axis_tdata holds blue, green, red; m_axis_tuser flags a
// clamped neighbour. The result holds in its register while m_axis_tready
// is low, and no input is taken meanwhile.
// Reset sets width and height to 256 and empties the sequencer; the image
// store keeps its contents and needs no clearing pass.
// Configuration writes take effect at the clock edge with i_cfg_we high.
module piecewise_affine_warp_sampler
    import paws_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [15:0] write_address, [39:16] write_pixel, [57:40] weight_a,
    // [75:58] weight_b, [93:76] weight_c, [109:94] first_vertex_x,
    // [125:110] first_vertex_y, [141:126] second_vertex_x,
    // [157:142] second_vertex_y, [173:158] third_vertex_x,
    // [189:174] third_vertex_y, [191:190] zero
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    // [0] command
    input  logic [0:0]           s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [7:0] blue, [15:8] green, [23:16] red
    output logic [23:0]          m_axis_tdata,
    // [0] clamped
    output logic [0:0]           m_axis_tuser,
    input  logic                 i_cfg_we,
    input  logic [0:0]           i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data
);

    typedef struct packed {
        logic [DIM_W-1:0] coord;
        logic             flag;
    } t_clamp;

    function automatic t_clamp clamp_coord(input logic signed [COORD_W-1:0] c,
                                           input logic [DIM_W-1:0] size);
        t_clamp                     res;
        logic signed [COORD_W-1:0]  lim;
        lim = signed'(COORD_W'(size)) - COORD_W'(1);
        if (c < 0) begin
            res.coord = '0;
            res.flag  = 1'b1;
        end else if (c > lim) begin
            res.coord = size - DIM_W'(1);
            res.flag  = 1'b1;
        end else begin
            res.coord = c[DIM_W-1:0];
            res.flag  = 1'b0;
        end
        return res;
    endfunction

    t_state r_state, n_state;
    logic [2:0] r_step, n_step;
    logic [1:0] r_chan, n_chan;

    logic [DIM_W-1:0] r_width, r_height;
    logic [DIM_W-1:0] eff_w, eff_h;

    logic [IN_DATA_W-1:0] r_in;
    logic                 in_xfer;
    logic                 wr_en;
    logic [PIX_AW-1:0]    ram_addr;
    logic [PIX_AW-1:0]    rd_addr;
    logic [PIXEL_W-1:0]   ram_rdata;

    t_mac_ctrl               mac_ctrl;
    logic signed [MUL_W-1:0] mac_a, mac_b;
    logic signed [ACC_W-1:0] acc;

    logic signed [WEIGHT_W-1:0] w_a, w_b, w_c;
    logic [VERTEX_W-1:0] v_x1, v_y1, v_x2, v_y2, v_x3, v_y3;

    logic signed [ACC_W-1:0]            r_xsum;
    logic signed [ACC_W-POINT_FRAC-1:0] x_whole, y_whole;
    logic signed [COORD_W-1:0]          x_lo, x_hi, y_lo, y_hi;
    t_clamp                             cl_c0, cl_c1, cl_r0, cl_r1;

    logic [FRACTION_BITS-1:0] r_s, r_t;
    logic [DIM_W-1:0]         r_c0, r_c1, r_r0, r_r1;
    logic                     r_flag;
    logic [PIX_AW-1:0]        r_base0, r_base1;
    logic [PIXEL_W-1:0]       r_q [4];
    logic [LEFT_W-1:0]        r_left, r_right;
    logic [7:0]               r_res [3];

    logic [SCALE_W-1:0] s_inv, t_inv;
    logic [7:0]         px_tl, px_bl, px_tr, px_br;
    logic [ACC_W-1:0]   rnd;

    assign eff_w = (r_width == '0) ? DIM_W'(1) : r_width;
    assign eff_h = (r_height == '0) ? DIM_W'(1) : r_height;

    assign w_a  = r_in[OFS_WA +: WEIGHT_W];
    assign w_b  = r_in[OFS_WB +: WEIGHT_W];
    assign w_c  = r_in[OFS_WC +: WEIGHT_W];
    assign v_x1 = r_in[OFS_X1 +: VERTEX_W];
    assign v_y1 = r_in[OFS_Y1 +: VERTEX_W];
    assign v_x2 = r_in[OFS_X2 +: VERTEX_W];
    assign v_y2 = r_in[OFS_Y2 +: VERTEX_W];
    assign v_x3 = r_in[OFS_X3 +: VERTEX_W];
    assign v_y3 = r_in[OFS_Y3 +: VERTEX_W];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign wr_en         = in_xfer && (s_axis_tuser[0] == CMD_WRITE)
                           && (21'(s_axis_tdata[OFS_ADDR +: ADDR_W]) < 21'(PIXEL_DEPTH));
    assign ram_addr      = wr_en ? PIX_AW'(s_axis_tdata[OFS_ADDR +: ADDR_W]) : rd_addr;

    paws_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (PIXEL_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_addr  (ram_addr),
        .i_wdata (s_axis_tdata[OFS_PIXEL +: PIXEL_W]),
        .o_rdata (ram_rdata)
    );

    paws_mac u_mac (
        .i_clk  (i_clk),
        .i_ctrl (mac_ctrl),
        .i_a    (mac_a),
        .i_b    (mac_b),
        .o_acc  (acc)
    );

    // floor split of the weighted point
    assign x_whole = r_xsum[ACC_W-1:POINT_FRAC];
    assign y_whole = acc[ACC_W-1:POINT_FRAC];
    assign x_lo    = COORD_W'(x_whole);
    assign x_hi    = x_lo + COORD_W'(1);
    assign y_lo    = COORD_W'(y_whole);
    assign y_hi    = y_lo + COORD_W'(1);
    assign cl_c0   = clamp_coord(x_lo, eff_w);
    assign cl_c1   = clamp_coord(x_hi, eff_w);
    assign cl_r0   = clamp_coord(y_lo, eff_h);
    assign cl_r1   = clamp_coord(y_hi, eff_h);

    assign s_inv = SCALE_W'(SCALE) - SCALE_W'(r_s);
    assign t_inv = SCALE_W'(SCALE) - SCALE_W'(r_t);
    assign px_tl = r_q[0][{r_chan, 3'b000} +: 8];
    assign px_bl = r_q[1][{r_chan, 3'b000} +: 8];
    assign px_tr = r_q[2][{r_chan, 3'b000} +: 8];
    assign px_br = r_q[3][{r_chan, 3'b000} +: 8];
    assign rnd   = acc + ACC_W'(ROUND_HALF);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_step   <= '0;
            r_chan   <= '0;
            r_width  <= DIM_RESET;
            r_height <= DIM_RESET;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_chan  <= n_chan;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                    CFG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_chan   = r_chan;
        mac_ctrl = '0;
        mac_a    = '0;
        mac_b    = '0;
        rd_addr  = '0;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer && (s_axis_tuser[0] == CMD_SAMPLE)) begin
                    n_state = ST_LOCATE;
                    n_step  = '0;
                end
            end
            ST_LOCATE: begin
                mac_ctrl.en    = 1'b1;
                mac_ctrl.clear = (r_step == 3'd0) || (r_step == 3'd3);
                case (r_step)
                    3'd0: begin mac_a = MUL_W'(w_a); mac_b = MUL_W'(v_x1); end
                    3'd1: begin mac_a = MUL_W'(w_b); mac_b = MUL_W'(v_x2); end
                    3'd2: begin mac_a = MUL_W'(w_c); mac_b = MUL_W'(v_x3); end
                    3'd3: begin mac_a = MUL_W'(w_a); mac_b = MUL_W'(v_y1); end
                    3'd4: begin mac_a = MUL_W'(w_b); mac_b = MUL_W'(v_y2); end
                    default: begin mac_a = MUL_W'(w_c); mac_b = MUL_W'(v_y3); end
                endcase
                if (r_step == 3'd5) begin
                    n_state = ST_CLAMP;
                    n_step  = '0;
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            ST_CLAMP: begin
                n_state = ST_ROWS;
                n_step  = '0;
            end
            ST_ROWS: begin
                mac_ctrl.en    = (r_step != 3'd2);
                mac_ctrl.clear = 1'b1;
                mac_a = MUL_W'((r_step == 3'd0) ? r_r0 : r_r1);
                mac_b = MUL_W'(eff_w);
                if (r_step == 3'd2) begin
                    n_state = ST_FETCH;
                    n_step  = '0;
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            ST_FETCH: begin
                case (r_step)
                    3'd0:    rd_addr = r_base0 + PIX_AW'(r_c0);
                    3'd1:    rd_addr = r_base1 + PIX_AW'(r_c0);
                    3'd2:    rd_addr = r_base0 + PIX_AW'(r_c1);
                    default: rd_addr = r_base1 + PIX_AW'(r_c1);
                endcase
                if (r_step == 3'd4) begin
                    n_state = ST_BLEND;
                    n_step  = '0;
                    n_chan  = '0;
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            ST_BLEND: begin
                mac_ctrl.en = (r_step != 3'd6);
                mac_ctrl.clear = (r_step == 3'd0) || (r_step == 3'd2)
                                 || (r_step == 3'd4);
                case (r_step)
                    3'd0: begin mac_a = MUL_W'(t_inv); mac_b = MUL_W'(px_tl); end
                    3'd1: begin mac_a = MUL_W'(r_t);   mac_b = MUL_W'(px_bl); end
                    3'd2: begin mac_a = MUL_W'(t_inv); mac_b = MUL_W'(px_tr); end
                    3'd3: begin mac_a = MUL_W'(r_t);   mac_b = MUL_W'(px_br); end
                    3'd4: begin mac_a = MUL_W'(s_inv); mac_b = MUL_W'(r_left); end
                    3'd5: begin mac_a = MUL_W'(r_s);   mac_b = MUL_W'(r_right); end
                    default: ;
                endcase
                if (r_step == 3'd6) begin
                    n_step = '0;
                    if (r_chan == 2'd2) begin
                        n_state = ST_OUT;
                    end else begin
                        n_chan = r_chan + 2'd1;
                    end
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            ST_OUT: begin
                if (m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_step  = '0;
                n_chan  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in <= s_axis_tdata;
        end
        if (r_state == ST_LOCATE && r_step == 3'd3) begin
            r_xsum <= acc;
        end
        if (r_state == ST_CLAMP) begin
            r_s    <= r_xsum[POINT_FRAC-1 -: FRACTION_BITS];
            r_t    <= acc[POINT_FRAC-1 -: FRACTION_BITS];
            r_c0   <= cl_c0.coord;
            r_c1   <= cl_c1.coord;
            r_r0   <= cl_r0.coord;
            r_r1   <= cl_r1.coord;
            r_flag <= cl_c0.flag | cl_c1.flag | cl_r0.flag | cl_r1.flag;
        end
        if (r_state == ST_ROWS && r_step == 3'd1) begin
            r_base0 <= acc[PIX_AW-1:0];
        end
        if (r_state == ST_ROWS && r_step == 3'd2) begin
            r_base1 <= acc[PIX_AW-1:0];
        end
        if (r_state == ST_FETCH && r_step != 3'd0) begin
            r_q[2'(r_step - 3'd1)] <= ram_rdata;
        end
        if (r_state == ST_BLEND && r_step == 3'd2) begin
            r_left <= acc[LEFT_W-1:0];
        end
        if (r_state == ST_BLEND && r_step == 3'd4) begin
            r_right <= acc[LEFT_W-1:0];
        end
        if (r_state == ST_BLEND && r_step == 3'd6) begin
            r_res[r_chan] <= rnd[2 * FRACTION_BITS +: 8];
        end
    end

    assign m_axis_tvalid = (r_state == ST_OUT);
    assign m_axis_tdata  = {r_res[2], r_res[1], r_res[0]};
    assign m_axis_tuser  = r_flag;

endmodule

### design/paws_ram.sv
// Generic single-port RAM with registered read data.
module paws_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/paws_mac.sv
// Shared signed multiply-accumulate unit used for every product of the sampler.
module paws_mac
    import paws_pkg::*;
(
    input  logic                    i_clk,
    input  t_mac_ctrl               i_ctrl,
    input  logic signed [MUL_W-1:0] i_a,
    input  logic signed [MUL_W-1:0] i_b,
    output logic signed [ACC_W-1:0] o_acc
);

    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] product;
    logic signed [ACC_W-1:0] n_acc;

    always_comb begin
        product = i_a * i_b;
        n_acc   = (i_ctrl.clear ? '0 : r_acc) + product;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

### sim/tb_piecewise_affine_warp_sampler.sv
// Self-checking stream testbench for the warp sampler: image loads, warped samples, sizes.
module tb_piecewise_affine_warp_sampler;
    import paws_pkg::*;

    localparam int SETTLE_CYCLES = 60;

    typedef struct packed {
        logic             cmd;
        logic [15:0]      addr;
        logic [23:0]      pixel;
        logic [2:0][17:0] wt;
        logic [2:0][15:0] vx;
        logic [2:0][15:0] vy;
    } t_cmd_item;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       clamped;
    } t_warp_px;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;
    logic [0:0]           s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [23:0]          m_axis_tdata;
    logic [0:0]           m_axis_tuser;
    logic                 i_cfg_we = 1'b0;
    logic [0:0]           i_cfg_index = '0;
    logic [DIM_W-1:0]     i_cfg_data = '0;

    logic [23:0]   image_copy [PIXEL_DEPTH];
    bit            loaded [PIXEL_DEPTH];
    int unsigned   img_width = DIM_RESET;
    int unsigned   img_height = DIM_RESET;
    bit            grey_image = 1'b0;

    t_cmd_item     cmd_queue [$];
    t_warp_px      warped_due [$];
    t_cmd_item     driven;
    int unsigned   send_gap = 0;
    int unsigned   send_calm = 0;
    int unsigned   recv_stall = 0;
    int unsigned   recv_calm = 0;
    int            errors = 0;

    piecewise_affine_warp_sampler i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic void locate_axis(input t_cmd_item it, input bit y_axis,
                                        output longint whole, output int unsigned frac);
        longint acc;
        longint biased;
        acc = 0;
        for (int k = 0; k < 3; k++)
            acc += longint'($signed(it.wt[k])) * longint'(y_axis ? it.vy[k] : it.vx[k]);
        biased = acc + (longint'(1) << 40);
        whole = (biased >>> POINT_FRAC) - (longint'(1) << (40 - POINT_FRAC));
        frac = int'((biased >>> (POINT_FRAC - FRACTION_BITS)) & ((1 << FRACTION_BITS) - 1));
    endfunction

    function automatic longint clamp_axis(input longint c, input longint size, inout bit hit);
        if (c < 0) begin
            hit = 1'b1;
            return 0;
        end
        if (c > size - 1) begin
            hit = 1'b1;
            return size - 1;
        end
        return c;
    endfunction

    function automatic void map_corners(input t_cmd_item it, output logic [3:0][15:0] addrs,
                                        output int unsigned s, output int unsigned t,
                                        output bit hit);
        longint w, h, xi, yi, c0, c1, r0, r1;
        w = (img_width == 0) ? 1 : img_width;
        h = (img_height == 0) ? 1 : img_height;
        hit = 1'b0;
        locate_axis(it, 1'b0, xi, s);
        locate_axis(it, 1'b1, yi, t);
        c0 = clamp_axis(xi, w, hit);
        c1 = clamp_axis(xi + 1, w, hit);
        r0 = clamp_axis(yi, h, hit);
        r1 = clamp_axis(yi + 1, h, hit);
        addrs[0] = 16'(r0 * w + c0);
        addrs[1] = 16'(r1 * w + c0);
        addrs[2] = 16'(r0 * w + c1);
        addrs[3] = 16'(r1 * w + c1);
    endfunction

    function automatic t_warp_px blend_sample(input t_cmd_item it);
        logic [3:0][15:0] addrs;
        int unsigned      s, t, left, right, mix;
        bit               hit;
        logic [2:0][7:0]  chan;
        t_warp_px         px;
        map_corners(it, addrs, s, t, hit);
        for (int c = 0; c < 3; c++) begin
            left  = (SCALE - t) * image_copy[addrs[0]][8*c +: 8]
                  + t * image_copy[addrs[1]][8*c +: 8];
            right = (SCALE - t) * image_copy[addrs[2]][8*c +: 8]
                  + t * image_copy[addrs[3]][8*c +: 8];
            mix = (SCALE - s) * left + s * right;
            chan[c] = 8'((mix + ROUND_HALF) >> (2 * FRACTION_BITS));
        end
        px.blue    = chan[0];
        px.green   = chan[1];
        px.red     = chan[2];
        px.clamped = hit;
        return px;
    endfunction

    function automatic int unsigned pick_gap(inout int unsigned calm);
        int unsigned r;
        if (calm != 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 149);
        if (r == 0) begin
            calm = 80;
            return 0;
        end
        if (r < 90)
            return 0;
        if (r < 140)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [23:0] new_pixel();
        logic [7:0] level;
        level = 8'($urandom);
        return grey_image ? {3{level}} : 24'($urandom);
    endfunction

    function automatic t_cmd_item random_item();
        t_cmd_item it;
        it.cmd   = CMD_SAMPLE;
        it.addr  = 16'($urandom);
        it.pixel = 24'($urandom);
        for (int k = 0; k < 3; k++) begin
            it.wt[k] = 18'($urandom);
            it.vx[k] = 16'($urandom);
            it.vy[k] = 16'($urandom);
        end
        return it;
    endfunction

    function automatic t_cmd_item point_item(input int wa, input logic [15:0] x,
                                             input logic [15:0] y);
        t_cmd_item it;
        it = random_item();
        it.wt[0] = 18'(wa);
        it.wt[1] = '0;
        it.wt[2] = '0;
        it.vx[0] = x;
        it.vy[0] = y;
        return it;
    endfunction

    function automatic void queue_write(input logic [15:0] addr, input logic [23:0] pixel);
        t_cmd_item it;
        it = random_item();
        it.cmd   = CMD_WRITE;
        it.addr  = addr;
        it.pixel = pixel;
        loaded[addr] = 1'b1;
        cmd_queue.insert(cmd_queue.size(), it);
    endfunction

    // Load every neighbour the sample will read that is not yet loaded, before the sample itself.
    function automatic void queue_sample(input t_cmd_item it);
        logic [3:0][15:0] addrs;
        int unsigned      s, t;
        bit               hit;
        map_corners(it, addrs, s, t, hit);
        for (int k = 0; k < 4; k++)
            if (!loaded[addrs[k]])
                queue_write(addrs[k], new_pixel());
        it.cmd = CMD_SAMPLE;
        cmd_queue.insert(cmd_queue.size(), it);
    endfunction

    function automatic t_cmd_item random_sample();
        t_cmd_item   it;
        int unsigned kind, span_x, span_y;
        int          wa, wb;
        it = random_item();
        kind = $urandom_range(0, 9);
        span_x = ((img_width == 0) ? 1 : img_width) * 64 + 64;
        span_y = ((img_height == 0) ? 1 : img_height) * 64 + 64;
        if (span_x > 65536)
            span_x = 65536;
        if (span_y > 65536)
            span_y = 65536;
        if (kind < 9) begin
            if (kind < 8) begin
                wa = $urandom_range(0, 65536);
                wb = $urandom_range(0, 65536 - wa);
            end else begin
                wa = $urandom_range(1, 131071);
                wb = -int'($urandom_range(0, 65536));
            end
            it.wt[0] = 18'(wa);
            it.wt[1] = 18'(wb);
            it.wt[2] = 18'(65536 - wa - wb);
            for (int k = 0; k < 3; k++) begin
                it.vx[k] = 16'($urandom_range(0, span_x - 1));
                it.vy[k] = 16'($urandom_range(0, span_y - 1));
            end
        end
        return it;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endfunction

    task automatic wait_drained();
        while (cmd_queue.size() != 0 || s_axis_tvalid || warped_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input int unsigned w, input int unsigned h);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_IMAGE_WIDTH;
        i_cfg_data  <= DIM_W'(w);
        @(posedge i_clk);
        img_width = w;
        i_cfg_index <= CFG_IMAGE_HEIGHT;
        i_cfg_data  <= DIM_W'(h);
        @(posedge i_clk);
        img_height = h;
        i_cfg_we <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (driven.cmd == CMD_WRITE)
                    image_copy[driven.addr] = driven.pixel;
                else
                    warped_due.insert(warped_due.size(), blend_sample(driven));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (cmd_queue.size() != 0) begin
                    driven = cmd_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {2'b00, driven.vy[2], driven.vx[2], driven.vy[1],
                                      driven.vx[1], driven.vy[0], driven.vx[0], driven.wt[2],
                                      driven.wt[1], driven.wt[0], driven.pixel, driven.addr};
                    s_axis_tuser  <= driven.cmd;
                    send_gap = pick_gap(send_calm);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_warp_px want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (warped_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h clamped %b",
                             $time, m_axis_tdata, m_axis_tuser);
                    errors++;
                end else begin
                    want = warped_due.pop_front();
                    check_field("blue", want.blue, m_axis_tdata[7:0]);
                    check_field("green", want.green, m_axis_tdata[15:8]);
                    check_field("red", want.red, m_axis_tdata[23:16]);
                    check_field("clamped", 8'(want.clamped), 8'(m_axis_tuser));
                end
            end
            if (recv_stall != 0) begin
                recv_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                recv_stall = pick_gap(recv_calm);
            end
        end
    end

    initial begin
        t_cmd_item   it;
        int unsigned w, h;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_write(16'd0, 24'h000000);
        queue_write(16'hFFFF, 24'hFFFFFF);
        queue_write(16'd1, 24'h010101);
        queue_write(16'd256, 24'hFFFFFF);
        queue_write(16'd257, 24'h7F7F7F);
        queue_sample(point_item(0, 16'd0, 16'd0));
        queue_sample(point_item(65536, 16'd32, 16'd0));
        queue_sample(point_item(65535, 16'd64, 16'd64));
        queue_sample(point_item(65536, 16'd16320, 16'd16320));
        queue_sample(point_item(-65536, 16'd64, 16'd64));
        queue_sample(point_item(-1, 16'd1, 16'd1));
        it = random_item();
        for (int k = 0; k < 3; k++) begin
            it.wt[k] = 18'h1FFFF;
            it.vx[k] = 16'hFFFF;
            it.vy[k] = 16'hFFFF;
        end
        queue_sample(it);
        for (int k = 0; k < 3; k++)
            it.wt[k] = 18'h20000;
        queue_sample(it);
        it.wt[0] = 18'd21845;
        it.wt[1] = 18'd21845;
        it.wt[2] = 18'd21846;
        it.vx = {16'd768, 16'd1920, 16'd640};
        it.vy = {16'd2560, 16'd320, 16'd1280};
        queue_sample(it);
        wait_drained();

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: begin w = 1;    h = 1;    end
                1: begin w = 1024; h = 1024; end
                2: begin w = 0;    h = 0;    end
                3: begin w = 3;    h = 5;    end
                4: begin w = 2047; h = 2047; end
                5: begin w = 1024; h = 2;    end
                6: begin w = 1;    h = 1024; end
                default: begin
                    w = $urandom_range(1, 64);
                    h = $urandom_range(1, 64);
                end
            endcase
            configure(w, h);
            grey_image = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < 75; n++) begin
                if ($urandom_range(0, 99) < 15)
                    queue_write(16'($urandom), new_pixel());
                else
                    queue_sample(random_sample());
            end
            wait_drained();
        end

        if (errors == 0)
            $display("PASS piecewise_affine_warp_sampler");
        else
            $display("FAIL piecewise_affine_warp_sampler");
        $finish;
    end

    initial begin
        #40000000;
        $display("FAIL piecewise_affine_warp_sampler");
        $finish;
    end

endmodule

### filelist.f
design/paws_pkg.sv
design/paws_ram.sv
design/paws_mac.sv
design/piecewise_affine_warp_sampler.sv
sim/tb_piecewise_affine_warp_sampler.sv
